### rtl/bfct_pkg.sv
// ----------------------------------------------------------------------------
// bfct_pkg: shared types and constants for the box frustum cull test
// Fixed-point widths, matrix and pipeline payload types used by every stage.
// ----------------------------------------------------------------------------
package bfct_pkg;

    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_W       = 64;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_PLANES  = 6;
    localparam int W_ROW       = 3;
    localparam int XLATE_COL   = 3;

    localparam int ELEM_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    // three full products plus the translation stay below 2^64; c +/- w below 2^65
    localparam int SUM_W  = PROD_W + 2;

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef elem_t [NUM_AXES-1:0] vec3_t;
    // indexed [column][row]
    typedef elem_t [NUM_ROWS-1:0][NUM_ROWS-1:0] mat_t;
    // indexed [row][axis][0 = low, 1 = high]
    typedef prod_t [NUM_ROWS-1:0][NUM_AXES-1:0][1:0] prod_set_t;
    // indexed [corner][row]
    typedef sum_t [NUM_CORNERS-1:0][NUM_ROWS-1:0] clip_t;

endpackage

### rtl/bfct_mul.sv
// ----------------------------------------------------------------------------
// bfct_mul: product stage
// Forms every matrix-element by box-coordinate product for low and high.
// ----------------------------------------------------------------------------
module bfct_mul import bfct_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  vec3_t     low,
    input  vec3_t     high,
    input  mat_t      mat,
    output logic      out_valid,
    input  logic      out_ready,
    output prod_set_t prod
);

    logic      valid_reg, valid_next;
    prod_set_t prod_reg, prod_next;

    function automatic prod_t mul_q(elem_t a, elem_t b);
        logic signed [ELEM_W-1:0] sa;
        logic signed [ELEM_W-1:0] sb;
        logic signed [PROD_W-1:0] p;
        sa = a;
        sb = b;
        p  = sa * sb;
        return prod_t'(p);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                prod_next[r][a][0] = mul_q(mat[a][r], low[a]);
                prod_next[r][a][1] = mul_q(mat[a][r], high[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

### rtl/bfct_add.sv
// ----------------------------------------------------------------------------
// bfct_add: clip coordinate adder stages
// Stage A sums translation with the x product and the y and z products;
// stage B combines them into the four clip coordinates of all eight corners.
// ----------------------------------------------------------------------------
module bfct_add import bfct_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  prod_set_t prod,
    input  mat_t      mat,
    output logic      out_valid,
    input  logic      out_ready,
    output clip_t     clip
);

    typedef sum_t [NUM_ROWS-1:0][1:0] tx_sum_t;
    typedef sum_t [NUM_ROWS-1:0][3:0] yz_sum_t;

    logic    va_reg, va_next, vb_reg, vb_next;
    logic    rdy_a, rdy_b;
    tx_sum_t tx_reg, tx_next;
    yz_sum_t yz_reg, yz_next;
    clip_t   clip_reg, clip_next;

    function automatic sum_t sext_prod(prod_t p);
        return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // translation element scaled by 1.0 into the product format
    function automatic sum_t sext_xlate(elem_t t);
        return {{(SUM_W-ELEM_W-FRAC_W){t[ELEM_W-1]}}, t, {FRAC_W{1'b0}}};
    endfunction

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb begin
        va_next = va_reg;
        vb_next = vb_reg;
        if (rdy_a) begin
            va_next = in_valid;
        end
        if (rdy_b) begin
            vb_next = va_reg;
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int s = 0; s < 2; s++) begin
                tx_next[r][s] = sext_xlate(mat[XLATE_COL][r]) + sext_prod(prod[r][0][s]);
            end
            for (int j = 0; j < 4; j++) begin
                yz_next[r][j] = sext_prod(prod[r][1][j % 2]) + sext_prod(prod[r][2][j / 2]);
            end
        end
    end

    // corner bit 0 picks x, bits 2:1 pick y and z
    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                clip_next[k][r] = tx_reg[r][k % 2] + yz_reg[r][k / 2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            tx_reg <= tx_next;
            yz_reg <= yz_next;
        end
        if (rdy_b && va_reg) begin
            clip_reg <= clip_next;
        end
    end

    assign out_valid = vb_reg;
    assign clip      = clip_reg;

endmodule

### rtl/bfct_plane.sv
// ----------------------------------------------------------------------------
// bfct_plane: clip plane test stage
// Checks all corners against the six planes and registers the verdict.
// ----------------------------------------------------------------------------
module bfct_plane import bfct_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  clip_t clip,
    output logic  out_valid,
    input  logic  out_ready,
    output logic  outside
);

    logic valid_reg, valid_next;
    logic outside_reg, outside_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_comb begin
        logic [NUM_PLANES-1:0] beyond;
        sum_t                  d_neg;
        sum_t                  d_pos;
        beyond = '1;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                // c < -w when c + w is negative; c > w when c - w is positive
                d_neg = clip[k][a] + clip[k][W_ROW];
                d_pos = clip[k][a] - clip[k][W_ROW];
                if (!d_neg[SUM_W-1]) begin
                    beyond[2*a] = 1'b0;
                end
                if (d_pos[SUM_W-1] || d_pos == '0) begin
                    beyond[2*a+1] = 1'b0;
                end
            end
        end
        outside_next = |beyond;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            outside_reg <= outside_next;
        end
    end

    assign out_valid = valid_reg;
    assign outside   = outside_reg;

endmodule

### rtl/box_frustum_cull_test_unit.sv
// ----------------------------------------------------------------------------
// box_frustum_cull_test_unit: axis-aligned box versus clip-space frustum
// Tests a stream of boxes against a clip matrix and flags boxes fully outside.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one box per request, low and high corners
//   in signed Q16.16. Result channel (m_valid/m_ready): one m_outside bit per
//   box, in request order; 1 when one clip plane rejects all eight corners.
//   Configuration: cfg_wr_en writes cfg_wr_data into matrix register
//   cfg_wr_index (two Q16.16 rows of one column each); indexes past the last
//   register are dropped. Write only while no request is in flight.
//   Stages from accept to m_valid: multiply, two add
//   stages, plane test. Throughput: one box per cycle; every stage holds its
//   own valid bit, so bubbles close up and the input keeps taking requests
//   while a result waits, until all four stages are full.
//   Stall: with m_ready low the result register holds; once the pipeline is
//   full s_ready drops, and nothing is lost or repeated.
//   Reset (aresetn low, synchronous): all stages empty, matrix cleared to zero.
// ----------------------------------------------------------------------------
module box_frustum_cull_test_unit import bfct_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_low_x,
    input  logic signed [31:0]   s_low_y,
    input  logic signed [31:0]   s_low_z,
    input  logic signed [31:0]   s_high_x,
    input  logic signed [31:0]   s_high_y,
    input  logic signed [31:0]   s_high_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_outside,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    logic [NUM_REGS-1:0][CFG_W-1:0] cfg_reg;
    mat_t      mat;
    vec3_t     low, high;
    prod_set_t prod;
    clip_t     clip;
    logic      mul_valid, add_ready, add_valid, plane_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en && cfg_wr_index < CFG_IDX_W'(NUM_REGS)) begin
            cfg_reg[cfg_wr_index[2:0]] <= cfg_wr_data;
        end
    end

    // column c, row r lives in register 2c + r/2, half r%2
    always_comb begin
        for (int c = 0; c < NUM_ROWS; c++) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                mat[c][r] = cfg_reg[2*c + r/2][ELEM_W*(r%2) +: ELEM_W];
            end
        end
    end

    assign low  = {s_low_z, s_low_y, s_low_x};
    assign high = {s_high_z, s_high_y, s_high_x};

    bfct_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .low       (low),
        .high      (high),
        .mat       (mat),
        .out_valid (mul_valid),
        .out_ready (add_ready),
        .prod      (prod)
    );

    bfct_add u_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (add_ready),
        .prod      (prod),
        .mat       (mat),
        .out_valid (add_valid),
        .out_ready (plane_ready),
        .clip      (clip)
    );

    bfct_plane u_plane (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (add_valid),
        .in_ready  (plane_ready),
        .clip      (clip),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .outside   (m_outside)
    );

    // input backpressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (mul_valid && add_valid && m_valid && !m_ready))
        else $error("s_ready low while the pipeline has room");

    // a new result only follows a valid plane-stage input
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(add_valid))
        else $error("result appeared without a request in the add stage");

    // stalled products stay put
    a_mul_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul_valid && !add_ready) |=> (mul_valid && $stable(prod)))
        else $error("product stage lost or changed a stalled request");

endmodule

### dv/box_cull_checker.sv
// ----------------------------------------------------------------------------
// box_cull_checker: result predictor and scoreboard for the frustum cull test
// Mirrors the clip matrix from the configuration writes, predicts the outside
// flag of every accepted box with wide exact arithmetic, and compares it with
// each returned result in order.
// ----------------------------------------------------------------------------
module box_cull_checker import bfct_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  elem_t                s_low_x,
    input  elem_t                s_low_y,
    input  elem_t                s_low_z,
    input  elem_t                s_high_x,
    input  elem_t                s_high_y,
    input  elem_t                s_high_z,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_outside,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    output int                   mismatch_count,
    output int                   boxes_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    logic             outside_expected_q [$];
    int               errors;

    // two rows of one column share a register, lower row in the low half
    function automatic logic signed [ELEM_W-1:0] matrix_elem(int col, int row);
        return matrix_regs[2 * col + row / 2][(row % 2) * ELEM_W +: ELEM_W];
    endfunction

    function automatic logic box_is_outside(vec3_t low, vec3_t high);
        logic signed [127:0]       clip [NUM_ROWS];
        logic signed [127:0]       term;
        logic signed [ELEM_W-1:0]  coord;
        logic [NUM_PLANES-1:0]     rejected;
        rejected = '1;
        for (int corner = 0; corner < NUM_CORNERS; corner++) begin
            for (int row = 0; row < NUM_ROWS; row++) begin
                // translation times w = 1.0, lifted to Q32.32
                clip[row] = matrix_elem(XLATE_COL, row);
                clip[row] = clip[row] <<< FRAC_W;
                for (int axis = 0; axis < NUM_AXES; axis++) begin
                    coord = corner[axis] ? high[axis] : low[axis];
                    term = matrix_elem(axis, row) * coord;
                    clip[row] = clip[row] + term;
                end
            end
            // a corner on a plane is not beyond it
            for (int axis = 0; axis < NUM_AXES; axis++) begin
                if (clip[axis] + clip[W_ROW] >= 0)
                    rejected[2 * axis] = 1'b0;
                if (clip[axis] - clip[W_ROW] <= 0)
                    rejected[2 * axis + 1] = 1'b0;
            end
        end
        return |rejected;
    endfunction

    always @(posedge aclk) begin : monitor
        logic predicted;
        if (!aresetn) begin
            foreach (matrix_regs[i])
                matrix_regs[i] = '0;
            outside_expected_q.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outside_expected_q.size() == 0) begin
                    errors++;
                    $error("outside: result with no box waiting, got %0b", m_outside);
                end else begin
                    predicted = outside_expected_q.pop_front();
                    if (m_outside !== predicted) begin
                        errors++;
                        $error("outside: expected %0b, got %0b", predicted, m_outside);
                    end
                end
            end
            if (s_valid && s_ready)
                outside_expected_q.push_back(box_is_outside({s_low_z, s_low_y, s_low_x},
                                                            {s_high_z, s_high_y, s_high_x}));
            // writes past the register file are dropped
            if (cfg_wr_en && cfg_wr_index < NUM_REGS)
                matrix_regs[cfg_wr_index[$clog2(NUM_REGS)-1:0]] = cfg_wr_data;
        end
        mismatch_count  <= errors;
        boxes_in_flight <= outside_expected_q.size();
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the box frustum cull test unit
// Loads a series of clip matrices (zero, identity, extremes, random) and
// streams directed and random boxes through the unit with random idling on
// both channels; the checker beside the unit predicts and compares results.
// ----------------------------------------------------------------------------
module testbench import bfct_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    Q_ONE           = 1 << FRAC_W;
    localparam elem_t Q_MAX           = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam elem_t Q_MIN           = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam int    RESET_CYCLES    = 8;
    localparam int    IDLE_PCT        = 12;
    localparam int    RX_HOLD_CYCLES  = 120;
    localparam int    DRAIN_CYCLES    = 8;
    localparam int    RANDOM_PHASES   = 10;
    localparam int    ITEMS_PER_PHASE = 160;
    localparam int    HOLD_PHASE      = 3;
    localparam int    STEADY_PHASE    = 5;

    typedef enum {MAT_FULL, MAT_EXTREME, MAT_VIEW} matrix_kind_t;

    typedef struct packed {
        vec3_t low;
        vec3_t high;
    } box_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 m_ready      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data  = '0;
    elem_t                s_low_x      = '0;
    elem_t                s_low_y      = '0;
    elem_t                s_low_z      = '0;
    elem_t                s_high_x     = '0;
    elem_t                s_high_y     = '0;
    elem_t                s_high_z     = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic                 m_outside;
    int                   mismatch_count;
    int                   boxes_in_flight;
    bit                   steady_mode  = 1'b0;
    bit                   rx_hold_req  = 1'b0;

    always #5 aclk = ~aclk;

    box_frustum_cull_test_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_low_x      (s_low_x),
        .s_low_y      (s_low_y),
        .s_low_z      (s_low_z),
        .s_high_x     (s_high_x),
        .s_high_y     (s_high_y),
        .s_high_z     (s_high_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_outside    (m_outside),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    box_cull_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_low_x         (s_low_x),
        .s_low_y         (s_low_y),
        .s_low_z         (s_low_z),
        .s_high_x        (s_high_x),
        .s_high_y        (s_high_y),
        .s_high_z        (s_high_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_outside       (m_outside),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .mismatch_count  (mismatch_count),
        .boxes_in_flight (boxes_in_flight)
    );

    // result side: random back-pressure, or one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #(2_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic box_t make_box(elem_t lx, elem_t ly, elem_t lz,
                                      elem_t hx, elem_t hy, elem_t hz);
        box_t b;
        b.low  = {lz, ly, lx};
        b.high = {hz, hy, hx};
        return b;
    endfunction

    function automatic elem_t rand_span(int span);
        return elem_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic box_t random_box();
        box_t  b;
        int    mode;
        elem_t centre;
        elem_t half;
        mode = $urandom_range(99);
        for (int axis = 0; axis < NUM_AXES; axis++) begin
            if (mode < 20) begin
                b.low[axis]  = $urandom;
                b.high[axis] = $urandom;
            end else begin
                centre = rand_span(6 * Q_ONE);
                half   = elem_t'($urandom_range(0, 2 * Q_ONE));
                b.low[axis]  = centre - half;
                b.high[axis] = centre + half;
                // swap the corners now and then
                if (mode < 30) begin
                    b.low[axis]  = centre + half;
                    b.high[axis] = centre - half;
                end
            end
        end
        return b;
    endfunction

    function automatic mat_t random_matrix(matrix_kind_t kind);
        mat_t m;
        for (int col = 0; col < NUM_ROWS; col++) begin
            for (int row = 0; row < NUM_ROWS; row++) begin
                case (kind)
                    MAT_FULL: begin
                        m[col][row] = $urandom;
                    end
                    MAT_EXTREME: begin
                        case ($urandom_range(3))
                            0:       m[col][row] = Q_MAX;
                            1:       m[col][row] = Q_MIN;
                            2:       m[col][row] = '0;
                            default: m[col][row] = elem_t'(Q_ONE);
                        endcase
                    end
                    default: begin
                        // small perspective-like matrix with w near a positive constant
                        if (row == W_ROW && col == XLATE_COL)
                            m[col][row] = elem_t'($urandom_range(Q_ONE / 2, 4 * Q_ONE));
                        else if (row == W_ROW)
                            m[col][row] = rand_span(Q_ONE / 4);
                        else if (col == XLATE_COL)
                            m[col][row] = rand_span(4 * Q_ONE);
                        else
                            m[col][row] = rand_span(2 * Q_ONE);
                    end
                endcase
            end
        end
        return m;
    endfunction

    task automatic load_matrix(mat_t m);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en    <= 1'b1;
            cfg_wr_index <= CFG_IDX_W'(i);
            cfg_wr_data  <= {m[i / 2][2 * (i % 2) + 1], m[i / 2][2 * (i % 2)]};
            @(posedge aclk);
        end
        // stray write past the register file: must be dropped
        cfg_wr_index <= CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
        cfg_wr_data  <= {$urandom, $urandom};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_box(box_t b);
        while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_low_x  <= b.low[0];
        s_low_y  <= b.low[1];
        s_low_z  <= b.low[2];
        s_high_x <= b.high[0];
        s_high_y <= b.high[1];
        s_high_z <= b.high[2];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (boxes_in_flight != 0) @(posedge aclk);
    endtask

    task automatic send_extreme_boxes();
        send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    endtask

    initial begin
        mat_t         m;
        matrix_kind_t kind;
        int           h;
        int           f;
        int           t;
        h = Q_ONE / 2;
        f = 3 * Q_ONE / 2;
        t = 2 * Q_ONE;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // matrix still cleared by reset: nothing can be outside
        send_extreme_boxes();
        wait_for_results();

        m = '0;
        for (int i = 0; i < NUM_ROWS; i++)
            m[i][i] = elem_t'(Q_ONE);
        load_matrix(m);
        send_box(make_box(-h, -h, -h, h, h, h));
        send_box(make_box(f, -h, -h, t, h, h));
        send_box(make_box(-t, -h, -h, -f, h, h));
        send_box(make_box(-h, f, -h, h, t, h));
        send_box(make_box(-h, -t, -h, h, -f, h));
        send_box(make_box(-h, -h, f, h, h, t));
        send_box(make_box(-h, -h, -t, h, h, -f));
        // corners touching a plane stay inside; one step past it does not
        send_box(make_box(Q_ONE, -h, -h, t, h, h));
        send_box(make_box(-t, -h, -h, -Q_ONE, h, h));
        send_box(make_box(Q_ONE + 1, -h, -h, t, h, h));
        send_box(make_box(t, -h, -h, f, h, h));
        send_box(make_box(-t, -t, -t, t, t, t));
        send_extreme_boxes();
        wait_for_results();

        load_matrix({(NUM_ROWS * NUM_ROWS){Q_MAX}});
        send_extreme_boxes();
        wait_for_results();

        load_matrix({(NUM_ROWS * NUM_ROWS){Q_MIN}});
        send_extreme_boxes();
        wait_for_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            kind = (phase == 0 || phase == 6) ? MAT_FULL :
                   (phase == 1) ? MAT_EXTREME : MAT_VIEW;
            steady_mode = (phase == STEADY_PHASE);
            load_matrix(random_matrix(kind));
            // stall results long enough to fill the pipe while boxes keep coming
            if (phase == HOLD_PHASE)
                rx_hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_box(random_box());
            wait_for_results();
        end
        steady_mode = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && boxes_in_flight == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
